/* sv/dqld_pkg.sv */
// ----------------------------------------------------------------------------
// DNS query-name label decoder package
// Shared types and constants for the label decoder: decode phases, the
// input item, the result item and the stage handshake bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dqld_pkg;

  // Message layout constants.
  localparam int unsigned HeaderBytes = 12;
  localparam logic [3:0]  HEADER_LAST = 4'(HeaderBytes - 1);
  localparam logic [7:0]  DOT_CHAR    = 8'h2E;

  // Name limit register: width, reset value and effective ceiling.
  localparam int unsigned LimitWidth  = 9;
  localparam logic [LimitWidth-1:0] LIMIT_RESET = 9'd256;
  localparam logic [LimitWidth-1:0] LIMIT_MAX   = 9'd256;

  // Decode phase of the current message.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LEN,
    PH_LABEL,
    PH_WAIT
  } phase_e;

  // One message byte as held in the input stage.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } item_t;

  // Input stage contents offered to the decoder.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic       error;
    logic [7:0] name_length;
  } result_t;

endpackage : dqld_pkg

`default_nettype wire

/* sv/dqld_byte_if.sv */
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel that carries one DNS message byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqld_byte_if;

  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);

endinterface : dqld_byte_if

`default_nettype wire

/* sv/dqld_name_if.sv */
// ----------------------------------------------------------------------------
// Decoded name channel
// Valid/ready channel that carries name characters and completion status.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqld_name_if;

  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       done_res;
  logic       error;
  logic [7:0] name_length;

  modport source (
    output valid, output out_char, output char_valid, output done_res,
    output error, output name_length, input ready
  );
  modport sink (
    input valid, input out_char, input char_valid, input done_res,
    input error, input name_length, output ready
  );

endinterface : dqld_name_if

`default_nettype wire

/* sv/dqld_in_reg.sv */
// ----------------------------------------------------------------------------
// Input stage register
// Captures one message byte per transaction and holds it until the decoder
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dqld_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  dqld_byte_if.sink            byte_i,
  input  wire logic            take_i,
  output dqld_pkg::stage_t     stage_o
);
  import dqld_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The stage can load whenever it is empty or its byte leaves this cycle.
  assign byte_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (byte_i.ready) begin
      valid_d = byte_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      item_q.in_byte <= byte_i.in_byte;
      item_q.last    <= byte_i.last;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule : dqld_in_reg

`default_nettype wire

/* sv/dqld_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dqld_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire dqld_pkg::result_t res_i,
  output logic                 free_o,
  dqld_name_if.source          name_o
);
  import dqld_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // A new result may enter when the register is empty or is being drained.
  assign free_o = !valid_q || name_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign name_o.valid       = valid_q;
  assign name_o.out_char    = res_q.out_char;
  assign name_o.char_valid  = res_q.char_valid;
  assign name_o.done_res    = res_q.done_res;
  assign name_o.error       = res_q.error;
  assign name_o.name_length = res_q.name_length;

endmodule : dqld_out_reg

`default_nettype wire

/* sv/dqld_core.sv */
// ----------------------------------------------------------------------------
// Label decoder core
// Message state machine: skips the header, walks the length-prefixed labels,
// emits characters and dots, and reports completion or error.
// ----------------------------------------------------------------------------
`default_nettype none

module dqld_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [8:0]      cfg_wdata_i,
  input  wire dqld_pkg::stage_t stage_i,
  input  wire logic            out_free_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output dqld_pkg::result_t    res_o
);
  import dqld_pkg::*;

  logic [LimitWidth-1:0] name_limit_q;
  phase_e                phase_q, phase_d;
  logic [3:0]            header_count_q, header_count_d;
  logic [7:0]            label_left_q, label_left_d;
  logic [7:0]            out_count_q, out_count_d;
  logic                  had_label_q, had_label_d;

  logic [LimitWidth-1:0] lim_eff;
  logic [9:0]            need;
  logic                  overflow;
  logic                  has_res;
  logic [7:0]            b;
  logic                  last;
  logic [7:0]            label_left_dec;
  logic [7:0]            out_count_inc;

  assign b              = stage_i.item.in_byte;
  assign last           = stage_i.item.last;
  assign label_left_dec = label_left_q - 8'd1;
  assign out_count_inc  = out_count_q + 8'd1;

  // Name limit register; values above the ceiling act as the ceiling.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      name_limit_q <= cfg_wdata_i;
    end
  end

  assign lim_eff = (name_limit_q > LIMIT_MAX) ? LIMIT_MAX : name_limit_q;

  // Overflow when count + dot + label length reaches limit - 1.
  assign need     = 10'(out_count_q) + 10'(had_label_q) + 10'(b) + 10'd1;
  assign overflow = need >= 10'(lim_eff);

  // Next state and result for the byte in the input stage.
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    label_left_d   = label_left_q;
    out_count_d    = out_count_q;
    had_label_d    = had_label_q;
    has_res        = 1'b0;
    res_o          = '0;

    unique case (phase_q)
      PH_HEADER: begin
        if (header_count_q >= HEADER_LAST) begin
          phase_d        = PH_LEN;
          header_count_d = '0;
          if (last) begin
            has_res        = 1'b1;
            res_o.done_res = 1'b1;
          end
        end else begin
          header_count_d = header_count_q + 4'd1;
          if (last) begin
            has_res        = 1'b1;
            res_o.done_res = 1'b1;
            res_o.error    = 1'b1;
          end
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          has_res           = 1'b1;
          res_o.done_res    = 1'b1;
          res_o.name_length = out_count_q;
          phase_d           = PH_WAIT;
        end else if (overflow || last) begin
          has_res        = 1'b1;
          res_o.done_res = 1'b1;
          res_o.error    = 1'b1;
          phase_d        = PH_WAIT;
        end else begin
          // A dot separates this label from the previous one.
          if (had_label_q) begin
            has_res          = 1'b1;
            res_o.out_char   = DOT_CHAR;
            res_o.char_valid = 1'b1;
            out_count_d      = out_count_inc;
          end
          had_label_d  = 1'b1;
          label_left_d = b;
          phase_d      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        has_res      = 1'b1;
        out_count_d  = out_count_inc;
        label_left_d = label_left_dec;
        if (label_left_dec == 8'd0) begin
          phase_d = PH_LEN;
        end
        if (last && (label_left_dec != 8'd0)) begin
          res_o.done_res = 1'b1;
          res_o.error    = 1'b1;
        end else begin
          res_o.out_char   = b;
          res_o.char_valid = 1'b1;
          if (last) begin
            res_o.done_res    = 1'b1;
            res_o.name_length = out_count_inc;
          end
        end
      end
      PH_WAIT: begin
        // Bytes after completion are dropped until the end of the message.
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // The end of a message always rearms the decoder.
    if (last) begin
      phase_d        = PH_HEADER;
      header_count_d = '0;
      label_left_d   = '0;
      out_count_d    = '0;
      had_label_d    = 1'b0;
    end
  end

  // A byte leaves the input stage unless its result has nowhere to go.
  assign take_o      = stage_i.valid && (!has_res || out_free_i);
  assign res_valid_o = take_o && has_res;

  // State registers, advanced once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      header_count_q <= '0;
      label_left_q   <= '0;
      out_count_q    <= '0;
      had_label_q    <= 1'b0;
    end else if (take_o) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      label_left_q   <= label_left_d;
      out_count_q    <= out_count_d;
      had_label_q    <= had_label_d;
    end
  end

`ifndef SYNTHESIS
  // The final byte of a message leaves all message state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && last |=> phase_q == PH_HEADER && out_count_q == 8'd0 &&
                       had_label_q == 1'b0 && header_count_q == 4'd0)
    else $error("message state not cleared after last byte");

  // Inside a label there is always at least one byte left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LABEL |-> label_left_q != 8'd0)
    else $error("label phase with no bytes left");

  // The limit check keeps the character count below the buffer ceiling.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q != 8'hFF)
    else $error("name length ran past the limit");

  // An error result never carries a character or a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.error |-> res_o.done_res && !res_o.char_valid &&
                                   res_o.name_length == 8'd0)
    else $error("error result carries payload");

  // No result is produced for a byte that is not consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> stage_i.valid && out_free_i)
    else $error("result issued without a consumed byte");
`endif

endmodule : dqld_core

`default_nettype wire

/* sv/dns_qname_label_decoder_top.sv */
// ----------------------------------------------------------------------------
// DNS query-name label decoder
// Turns the question name of a DNS message into a dotted character stream.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one message byte per transaction, header first, with last
//   set on the final byte. name_o carries zero or one transaction per byte:
//   a name character (label byte or dot), a completion with the name length,
//   or a completion with error, after which the receiver drops the characters
//   it already got for that message.
//   cfg_we_i/cfg_wdata_i write the name limit (buffer size with terminator);
//   write it only while the block is idle.
//   Path: an accepted byte is registered in the input register, decoded, and
//   its result is registered in the result register before reaching name_o.
//   Throughput: one byte per cycle while the result register is free, set by
//   the single decode step between the input and result registers.
//   Reset: the name limit returns to 256 and the decoder waits for a header.
//   Stall: a pending result holds in the result register; one more byte may
//   wait in the input register, after which byte_i.ready drops. Bytes that
//   give no result still pass while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_qname_label_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  dqld_byte_if.sink       byte_i,
  dqld_name_if.source     name_o
);
  import dqld_pkg::*;

  stage_t  stage;
  result_t res;
  logic    take;
  logic    res_valid;
  logic    out_free;

  // Input register stage.
  dqld_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .stage_o (stage)
  );

  // Decode step and message state.
  dqld_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stage_i     (stage),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  dqld_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_valid),
    .res_i  (res),
    .free_o (out_free),
    .name_o (name_o)
  );

endmodule : dns_qname_label_decoder_top

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// DNS query-name label decoder testbench
// Sends DNS messages byte by byte through the valid/ready byte channel and
// checks every name transaction against a cycle-free decode model kept in
// the bench. Stimulus is a short directed set followed by random messages:
// well-formed names, truncated streams, short headers, overlong names and
// noise. The name limit is rewritten between phases while the block is idle,
// and both channel ends idle at random under several traffic mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  import dqld_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;

  dqld_byte_if byte_bus ();
  dqld_name_if name_bus ();

  dns_qname_label_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (byte_bus),
    .name_o      (name_bus)
  );

  // Bytes waiting to be offered and name transactions still owed by the block.
  item_t      pending_bytes[$];
  result_t    name_expect[$];
  logic [7:0] msg_bytes[$];
  int         queued_bytes = 0;

  // Decode model state, mirrored from the block's behavior.
  logic [8:0] name_limit = LIMIT_RESET;
  phase_e     dec_phase  = PH_HEADER;
  logic [3:0] hdr_count  = '0;
  logic [7:0] label_left = '0;
  logic [7:0] out_count  = '0;
  logic       had_label  = 1'b0;

  // Traffic shaping and bookkeeping.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  err_count     = 0;
  int  results_seen  = 0;
  int  hold_left     = 0;
  bit  pressure_done = 1'b0;
  bit  byte_taken    = 1'b0;

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Advance the decode model by one accepted byte.
  task automatic decode_step(input item_t it);
    result_t r;
    bit      emit;
    int      lim;
    r    = '0;
    emit = 1'b0;
    lim  = (name_limit > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(name_limit);
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_count >= HEADER_LAST) begin
          dec_phase = PH_LEN;
          hdr_count = '0;
          if (it.last) begin
            r.done_res = 1'b1;
            emit       = 1'b1;
          end
        end else begin
          hdr_count = hdr_count + 4'd1;
          if (it.last) begin
            r.done_res = 1'b1;
            r.error    = 1'b1;
            emit       = 1'b1;
          end
        end
      end
      PH_LEN: begin
        if (it.in_byte == 8'd0) begin
          r.done_res    = 1'b1;
          r.name_length = out_count;
          emit          = 1'b1;
          dec_phase     = PH_WAIT;
        end else if (int'(out_count) + int'(had_label) + int'(it.in_byte) >= lim - 1
                     || it.last) begin
          r.done_res = 1'b1;
          r.error    = 1'b1;
          emit       = 1'b1;
          dec_phase  = PH_WAIT;
        end else begin
          // A dot separates this label from the previous one.
          if (had_label) begin
            r.out_char   = DOT_CHAR;
            r.char_valid = 1'b1;
            emit         = 1'b1;
            out_count    = out_count + 8'd1;
          end
          had_label  = 1'b1;
          label_left = it.in_byte;
          dec_phase  = PH_LABEL;
        end
      end
      PH_LABEL: begin
        out_count  = out_count + 8'd1;
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) dec_phase = PH_LEN;
        if (it.last) begin
          if (label_left == 8'd0) begin
            r.out_char    = it.in_byte;
            r.char_valid  = 1'b1;
            r.done_res    = 1'b1;
            r.name_length = out_count;
          end else begin
            r.done_res = 1'b1;
            r.error    = 1'b1;
          end
        end else begin
          r.out_char   = it.in_byte;
          r.char_valid = 1'b1;
        end
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    // The last byte always starts a fresh message.
    if (it.last) begin
      dec_phase  = PH_HEADER;
      hdr_count  = '0;
      label_left = '0;
      out_count  = '0;
      had_label  = 1'b0;
    end
    if (emit) name_expect.push_back(r);
  endtask

  // Compare one field of a name transaction.
  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", field, want, got);
      err_count++;
    end
  endfunction

  // Sample both channels at the rising edge: update the model, check results.
  always @(posedge clk_i) begin
    result_t want;
    byte_taken = rst_ni && byte_bus.valid && byte_bus.ready;
    if (byte_taken) decode_step({byte_bus.in_byte, byte_bus.last});
    if (rst_ni && name_bus.valid && name_bus.ready) begin
      results_seen++;
      if (name_expect.size() == 0) begin
        $error("unexpected name transaction: out_char 0x%02h done %0b error %0b",
               name_bus.out_char, name_bus.done_res, name_bus.error);
        err_count++;
      end else begin
        want = name_expect.pop_front();
        check_field("out_char", want.out_char, name_bus.out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(name_bus.char_valid));
        check_field("done_res", 8'(want.done_res), 8'(name_bus.done_res));
        check_field("error", 8'(want.error), 8'(name_bus.error));
        check_field("name_length", want.name_length, name_bus.name_length);
      end
    end
  end

  // Byte driver: offer the next pending byte once the current one is taken.
  always @(negedge clk_i) begin
    item_t nxt;
    bit    offer;
    if (rst_ni && (!byte_bus.valid || byte_taken)) begin
      offer = (pending_bytes.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      if (offer) begin
        nxt = pending_bytes.pop_front();
        byte_bus.in_byte <= nxt.in_byte;
        byte_bus.last    <= nxt.last;
        byte_bus.valid   <= 1'b1;
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // Name receiver: random ready, plus one long hold-off to back the block up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      name_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      = hold_left - 1;
      name_bus.ready <= 1'b0;
    end else if (!pressure_done && results_seen >= 40) begin
      hold_left      = 300;
      pressure_done  = 1'b1;
      name_bus.ready <= 1'b0;
    end else begin
      name_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_header(input int count);
    repeat (count) msg_bytes.push_back(rand_byte());
  endtask

  task automatic add_label(input int len);
    msg_bytes.push_back(8'(len));
    repeat (len) msg_bytes.push_back(rand_byte());
  endtask

  // Move the assembled message to the driver, flagging its final byte.
  task automatic commit_message();
    item_t it;
    foreach (msg_bytes[i]) begin
      it.in_byte = msg_bytes[i];
      it.last    = (i == msg_bytes.size() - 1);
      pending_bytes.push_back(it);
    end
    queued_bytes += msg_bytes.size();
    msg_bytes.delete();
  endtask

  // Header, a few labels, then the terminator and some trailing bytes, or
  // else a stream that stops right on the final byte of a label.
  task automatic build_name(input bit end_on_label);
    int labels;
    int len;
    add_header(12);
    labels = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < labels; i++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
      add_label(len);
    end
    if (!end_on_label || labels == 0) begin
      msg_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(rand_byte());
    end
  endtask

  // One random message drawn from a mix weighted toward well-formed names.
  task automatic random_message();
    int pick;
    int keep;
    int goal;
    int total;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      build_name($urandom_range(0, 9) == 0);
    end else if (pick < 75) begin
      add_header($urandom_range(1, 11));
    end else if (pick < 80) begin
      add_header(12);
    end else if (pick < 90) begin
      // Stream cut off somewhere after the header.
      build_name(1'b0);
      keep = $urandom_range(13, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else if (pick < 95) begin
      // Long names that run into the name limit.
      add_header(12);
      goal  = $urandom_range(150, 280);
      total = 0;
      while (total < goal) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 255) : $urandom_range(30, 63);
        add_label(len);
        total += len + 1;
      end
      msg_bytes.push_back(8'h00);
    end else begin
      repeat ($urandom_range(1, 40)) msg_bytes.push_back(rand_byte());
    end
    commit_message();
  endtask

  task automatic random_traffic(input int count);
    int target;
    target = queued_bytes + count;
    while (queued_bytes < target) random_message();
  endtask

  // Wait until every byte is taken and every result has arrived, then let
  // the pipeline settle for bytes that produce no result.
  task automatic drain();
    while (pending_bytes.size() != 0 || byte_bus.valid || name_expect.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [8:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    name_limit  = value;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Directed messages covering each completion case.
  task automatic directed_messages();
    // Header cut short.
    add_header(3);
    commit_message();
    // Stream ends on the twelfth header byte: empty name.
    add_header(12);
    commit_message();
    // Two labels with extreme content bytes, terminator, then ignored bytes.
    add_header(12);
    msg_bytes.push_back(8'd2);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'd1);
    msg_bytes.push_back(DOT_CHAR);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h00);
    commit_message();
    // Stream ends exactly on the final byte of a label.
    add_header(12);
    add_label(3);
    commit_message();
    // Stream ends inside a label.
    add_header(12);
    msg_bytes.push_back(8'd4);
    msg_bytes.push_back(8'h41);
    msg_bytes.push_back(8'h42);
    commit_message();
    // Stream ends on a nonzero length byte.
    add_header(12);
    msg_bytes.push_back(8'd5);
    commit_message();
    // Label too long for the name buffer, followed by an ignored byte.
    add_header(12);
    msg_bytes.push_back(8'hFF);
    msg_bytes.push_back(8'h7F);
    commit_message();
  endtask

  // Main sequence.
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    byte_bus.valid   = 1'b0;
    byte_bus.in_byte = '0;
    byte_bus.last    = 1'b0;
    name_bus.ready   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset limit, sender mostly busy, receiver often stalled.
    set_idle(15, 51);
    directed_messages();
    random_traffic(100);
    drain();

    write_limit(9'd3);
    random_traffic(40);
    drain();

    // Sender often idle, receiver mostly ready; limit above the ceiling.
    set_idle(51, 15);
    write_limit(9'd511);
    random_traffic(70);
    drain();

    write_limit(9'd20);
    random_traffic(70);
    drain();

    // Back-to-back traffic with no idling at either end.
    set_idle(0, 0);
    write_limit(9'd0);
    random_traffic(30);
    drain();

    write_limit(9'd2);
    random_traffic(20);
    drain();

    write_limit(9'd256);
    random_traffic(70);
    drain();

    write_limit(9'd40);
    random_traffic(40);
    drain();

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule : tb_top

`default_nettype wire

/* sim.f */
sv/dqld_pkg.sv
sv/dqld_byte_if.sv
sv/dqld_name_if.sv
sv/dqld_in_reg.sv
sv/dqld_out_reg.sv
sv/dqld_core.sv
sv/dns_qname_label_decoder_top.sv
verif/tb_top.sv
